[rtl/core/necir_pkg.sv]
package necir_pkg;

    localparam int unsigned DUR_W  = 16;
    localparam int unsigned CODE_W = 32;

    localparam int unsigned HDR_MARK_US    = 9000;
    localparam int unsigned HDR_SPACE_US   = 4500;
    localparam int unsigned BIT_MARK_US    = 560;
    localparam int unsigned ONE_SPACE_US   = 1690;
    localparam int unsigned ZERO_SPACE_US  = 560;
    localparam int unsigned SPACE_SPLIT_US = (ONE_SPACE_US + ZERO_SPACE_US) / 2;

    localparam logic [DUR_W-1:0] HDR_MARK_LO  = DUR_W'(HDR_MARK_US * 7 / 10);
    localparam logic [DUR_W-1:0] HDR_MARK_HI  = DUR_W'(HDR_MARK_US * 13 / 10);
    localparam logic [DUR_W-1:0] HDR_SPACE_LO = DUR_W'(HDR_SPACE_US * 7 / 10);
    localparam logic [DUR_W-1:0] HDR_SPACE_HI = DUR_W'(HDR_SPACE_US * 13 / 10);
    localparam logic [DUR_W-1:0] BIT_MARK_LO  = DUR_W'(BIT_MARK_US * 7 / 10);
    localparam logic [DUR_W-1:0] BIT_MARK_HI  = DUR_W'(BIT_MARK_US * 13 / 10);
    localparam logic [DUR_W-1:0] SPACE_SPLIT  = DUR_W'(SPACE_SPLIT_US);

    localparam logic [1:0] SYM_HDR_MARK  = 2'd0;
    localparam logic [1:0] SYM_HDR_SPACE = 2'd1;
    localparam logic [1:0] SYM_BIT_MARK  = 2'd2;
    localparam logic [1:0] SYM_BIT_SPACE = 2'd3;

    typedef struct packed {
        logic window_fail;
        logic space_one;
    } t_sym_result;

endpackage

[rtl/core/necir_if.sv]
interface necir_in_if;
    logic                        valid;
    logic                        ready;
    logic [necir_pkg::DUR_W-1:0] duration_us;
    logic                        end_of_capture;

    modport source (output valid, output duration_us, output end_of_capture, input ready);
    modport sink   (input valid, input duration_us, input end_of_capture, output ready);
endinterface

interface necir_out_if;
    logic                         valid;
    logic                         ready;
    logic                         decode_ok;
    logic [necir_pkg::CODE_W-1:0] frame_code;

    modport source (output valid, output decode_ok, output frame_code, input ready);
    modport sink   (input valid, input decode_ok, input frame_code, output ready);
endinterface

[rtl/core/nec_ir_pulse_decoder.sv]
// channel | dir | beat payload                     | result
// i_in    | in  | duration_us[15:0], end_of_capture | one beat per pulse
// o_out   | out | decode_ok, frame_code[31:0]       | one beat per capture
//
// One pulse per cycle unless a result stalls; each result is output-registered.
// Input register feeds a single decode stage whose state updates per consumed pulse.
// Synchronous active-low reset clears the pulse counter, fail flag and both valids.
// A stalled result holds a following end-of-capture beat in the input register;
// input then stops until the result drains. Other pulses flow during the stall.
module nec_ir_pulse_decoder #(
    parameter int unsigned CODE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    necir_in_if.sink           i_in,
    necir_out_if.source        o_out
);

    localparam int unsigned FRAME = 2 + 2 * CODE_BITS;
    localparam int unsigned IW    = $clog2(FRAME + 1);
    localparam int unsigned BW    = $clog2(CODE_BITS);

    logic                        r_in_valid;
    logic [necir_pkg::DUR_W-1:0] r_in_dur;
    logic                        r_in_last;

    logic [IW-1:0]        r_idx;
    logic [CODE_BITS-1:0] r_acc;
    logic                 r_failed;

    logic                         r_out_valid;
    logic                         r_out_ok;
    logic [necir_pkg::CODE_W-1:0] r_out_code;

    logic                   w_consume;
    logic [1:0]             w_kind;
    necir_pkg::t_sym_result w_res;
    logic [IW-1:0]          w_bit_off;
    logic [BW-1:0]          w_bit_pos;
    logic [IW-1:0]          n_idx;
    logic [CODE_BITS-1:0]   n_acc;
    logic                   n_failed;
    logic                   w_ok;
    logic [necir_pkg::CODE_W-1:0] w_code;

    assign w_consume  = r_in_valid && (!r_in_last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_dur  <= i_in.duration_us;
            r_in_last <= i_in.end_of_capture;
        end
    end

    always_comb begin
        if (r_idx == IW'(0)) begin
            w_kind = necir_pkg::SYM_HDR_MARK;
        end else if (r_idx == IW'(1)) begin
            w_kind = necir_pkg::SYM_HDR_SPACE;
        end else if (!r_idx[0]) begin
            w_kind = necir_pkg::SYM_BIT_MARK;
        end else begin
            w_kind = necir_pkg::SYM_BIT_SPACE;
        end
    end

    necir_symbol_check u_check (
        .i_duration_us (r_in_dur),
        .i_kind        (w_kind),
        .o_result      (w_res)
    );

    assign w_bit_off = (r_idx - IW'(3)) >> 1;
    assign w_bit_pos = w_bit_off[BW-1:0];

    always_comb begin
        n_idx    = r_idx;
        n_acc    = r_acc;
        n_failed = r_failed;
        if (r_idx < IW'(FRAME)) begin
            n_idx    = r_idx + IW'(1);
            n_failed = r_failed || w_res.window_fail;
            if (w_kind == necir_pkg::SYM_BIT_SPACE && w_res.space_one) begin
                n_acc = r_acc | (CODE_BITS'(1) << w_bit_pos);
            end
        end
    end

    assign w_ok = !n_failed && (n_idx >= IW'(FRAME));

    generate
        if (CODE_BITS >= necir_pkg::CODE_W) begin : g_code_wide
            assign w_code = n_acc[necir_pkg::CODE_W-1:0];
        end else begin : g_code_narrow
            assign w_code = {{(necir_pkg::CODE_W - CODE_BITS){1'b0}}, n_acc};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_acc       <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_consume) begin
                if (r_in_last) begin
                    r_idx       <= '0;
                    r_acc       <= '0;
                    r_failed    <= 1'b0;
                    r_out_valid <= 1'b1;
                end else begin
                    r_idx    <= n_idx;
                    r_acc    <= n_acc;
                    r_failed <= n_failed;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_consume && r_in_last) begin
            r_out_ok   <= w_ok;
            r_out_code <= w_ok ? w_code : '0;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.decode_ok  = r_out_ok;
    assign o_out.frame_code = r_out_code;

endmodule

[rtl/core/necir_symbol_check.sv]
module necir_symbol_check (
    input  logic [necir_pkg::DUR_W-1:0] i_duration_us,
    input  logic [1:0]                  i_kind,
    output necir_pkg::t_sym_result      o_result
);

    always_comb begin
        o_result.window_fail = 1'b0;
        o_result.space_one   = 1'b0;
        unique case (i_kind)
            necir_pkg::SYM_HDR_MARK: begin
                o_result.window_fail = (i_duration_us < necir_pkg::HDR_MARK_LO) ||
                                       (i_duration_us > necir_pkg::HDR_MARK_HI);
            end
            necir_pkg::SYM_HDR_SPACE: begin
                o_result.window_fail = (i_duration_us < necir_pkg::HDR_SPACE_LO) ||
                                       (i_duration_us > necir_pkg::HDR_SPACE_HI);
            end
            necir_pkg::SYM_BIT_MARK: begin
                o_result.window_fail = (i_duration_us < necir_pkg::BIT_MARK_LO) ||
                                       (i_duration_us > necir_pkg::BIT_MARK_HI);
            end
            default: begin
                o_result.space_one = i_duration_us > necir_pkg::SPACE_SPLIT;
            end
        endcase
    end

endmodule

[rtl/core/necir_checker.sv]
module necir_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_decode_ok,
    input logic [necir_pkg::CODE_W-1:0] i_frame_code
);

    a_fail_code_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_decode_ok) |-> (i_frame_code == '0)
    ) else $error("failed frame carries nonzero code");

    a_reset_clears_out: assert property (
        @(posedge i_clk)
        !i_rst_n |=> !i_out_valid
    ) else $error("result valid after reset");

    a_out_valid_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid
    ) else $error("result beat dropped while stalled");

    a_out_payload_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_decode_ok) && $stable(i_frame_code))
    ) else $error("result payload changed while stalled");

endmodule

bind nec_ir_pulse_decoder necir_checker u_necir_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_decode_ok  (o_out.decode_ok),
    .i_frame_code (o_out.frame_code)
);

[bench/nec_ir_checker.sv]
module nec_ir_checker #(
    parameter int unsigned CODE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    necir_in_if         i_pulse,
    necir_out_if        i_result,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DUR_W            = necir_pkg::DUR_W;
    localparam int unsigned CODE_W           = necir_pkg::CODE_W;
    localparam int unsigned FRAME_SYMBOLS    = 2 + 2 * CODE_BITS;
    localparam int unsigned SHOWN_MISMATCHES = 10;

    typedef struct packed {
        logic              decode_ok;
        logic [CODE_W-1:0] frame_code;
    } t_frame_result;

    int unsigned   symbols_seen = 0;
    logic [63:0]   code_bits = '0;
    logic          frame_bad = 1'b0;
    t_frame_result frames_due[$];
    int unsigned   mismatches = 0;
    int unsigned   frames_waiting = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = frames_waiting;

    function automatic logic in_window(logic [DUR_W-1:0] dur, int unsigned nominal);
        return dur >= nominal * 7 / 10 && dur <= nominal * 13 / 10;
    endfunction

    task automatic clear_frame();
        symbols_seen = 0;
        code_bits    = '0;
        frame_bad    = 1'b0;
    endtask

    task automatic decode_pulse(logic [DUR_W-1:0] dur, logic last);
        t_frame_result verdict;
        if (symbols_seen < FRAME_SYMBOLS) begin
            if (symbols_seen == 0) begin
                if (!in_window(dur, necir_pkg::HDR_MARK_US)) frame_bad = 1'b1;
            end else if (symbols_seen == 1) begin
                if (!in_window(dur, necir_pkg::HDR_SPACE_US)) frame_bad = 1'b1;
            end else if (symbols_seen % 2 == 0) begin
                if (!in_window(dur, necir_pkg::BIT_MARK_US)) frame_bad = 1'b1;
            end else if (dur > necir_pkg::SPACE_SPLIT_US && (symbols_seen - 3) / 2 < 64) begin
                code_bits[(symbols_seen - 3) / 2] = 1'b1;
            end
            symbols_seen++;
        end
        if (last) begin
            verdict.decode_ok  = !frame_bad && symbols_seen >= FRAME_SYMBOLS;
            verdict.frame_code = verdict.decode_ok ? code_bits[CODE_W-1:0] : '0;
            frames_due.push_back(verdict);
            clear_frame();
        end
    endtask

    task automatic check_result(logic ok, logic [CODE_W-1:0] code);
        t_frame_result want;
        if (frames_due.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
                $display("unexpected result beat: decode_ok=%0b frame_code=%h", ok, code);
        end else begin
            want = frames_due.pop_front();
            if (ok !== want.decode_ok || code !== want.frame_code) begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display("result mismatch: expected decode_ok=%0b frame_code=%h, %s%0b %s%h",
                             want.decode_ok, want.frame_code,
                             "got decode_ok=", ok, "frame_code=", code);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame();
            frames_due.delete();
        end else begin
            if (i_pulse.valid === 1'b1 && i_pulse.ready === 1'b1)
                decode_pulse(i_pulse.duration_us, i_pulse.end_of_capture);
            if (i_result.valid === 1'b1 && i_result.ready === 1'b1)
                check_result(i_result.decode_ok, i_result.frame_code);
        end
        frames_waiting = frames_due.size();
    end

endmodule

[bench/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DUR_W          = necir_pkg::DUR_W;
    localparam int unsigned HDR_MARK_US    = necir_pkg::HDR_MARK_US;
    localparam int unsigned HDR_SPACE_US   = necir_pkg::HDR_SPACE_US;
    localparam int unsigned BIT_MARK_US    = necir_pkg::BIT_MARK_US;
    localparam int unsigned SPACE_SPLIT_US = necir_pkg::SPACE_SPLIT_US;

    localparam int unsigned FRAME_BITS     = 32;
    localparam int unsigned FRAME_SYMBOLS  = 2 + 2 * FRAME_BITS;
    localparam int unsigned PULSE_BUDGET   = 1665;
    localparam int unsigned RX_HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned IDLE_PERCENT   = 38;

    typedef enum logic [1:0] {
        CAP_CLEAN,
        CAP_BROKEN,
        CAP_SHORT,
        CAP_NOISE
    } t_capture_kind;

    logic        i_clk;
    logic        i_rst_n;
    int unsigned pulses_sent = 0;
    int unsigned mismatch_count;
    int unsigned results_pending;

    necir_in_if  pulse_if ();
    necir_out_if result_if ();

    nec_ir_pulse_decoder #(
        .CODE_BITS (FRAME_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pulse_if),
        .o_out   (result_if)
    );

    nec_ir_checker #(
        .CODE_BITS (FRAME_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pulse      (pulse_if),
        .i_result     (result_if),
        .o_fail_count (mismatch_count),
        .o_pending    (results_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic bit steady_stretch();
        return pulses_sent >= 700 && pulses_sent < 1000;
    endfunction

    function automatic logic [DUR_W-1:0] pulse_in_window(int unsigned nominal);
        int unsigned lo;
        int unsigned hi;
        lo = nominal * 7 / 10;
        hi = nominal * 13 / 10;
        case ($urandom_range(3, 0))
            0:       return DUR_W'(lo);
            1:       return DUR_W'(hi);
            default: return DUR_W'($urandom_range(hi, lo));
        endcase
    endfunction

    function automatic logic [DUR_W-1:0] pulse_out_of_window(int unsigned nominal);
        int unsigned lo;
        int unsigned hi;
        lo = nominal * 7 / 10;
        hi = nominal * 13 / 10;
        case ($urandom_range(5, 0))
            0:       return DUR_W'(lo - 1);
            1:       return DUR_W'(hi + 1);
            2:       return '0;
            3:       return '1;
            4:       return DUR_W'($urandom_range(lo - 1, 0));
            default: return DUR_W'($urandom_range(16'hFFFF, hi + 1));
        endcase
    endfunction

    function automatic logic [DUR_W-1:0] bit_space(bit one);
        if (one) begin
            case ($urandom_range(3, 0))
                0:       return DUR_W'(SPACE_SPLIT_US + 1);
                1:       return '1;
                default: return DUR_W'($urandom_range(2400, SPACE_SPLIT_US + 1));
            endcase
        end
        case ($urandom_range(3, 0))
            0:       return DUR_W'(SPACE_SPLIT_US);
            1:       return '0;
            default: return DUR_W'($urandom_range(SPACE_SPLIT_US, 0));
        endcase
    endfunction

    task automatic send_pulse(logic [DUR_W-1:0] pulse, logic last);
        while (!steady_stretch() && $urandom_range(99, 0) < IDLE_PERCENT) begin
            pulse_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pulse_if.valid          <= 1'b1;
        pulse_if.duration_us    <= pulse;
        pulse_if.end_of_capture <= last;
        do @(posedge i_clk); while (pulse_if.ready !== 1'b1);
        pulses_sent++;
    endtask

    task automatic send_capture(t_capture_kind kind);
        int unsigned      length;
        int unsigned      broken_at;
        int unsigned      slot;
        int unsigned      nominal;
        logic [DUR_W-1:0] pulse;
        broken_at = FRAME_SYMBOLS;
        case (kind)
            CAP_CLEAN: begin
                length = FRAME_SYMBOLS + ($urandom_range(1, 0) ? $urandom_range(4, 1) : 0);
            end
            CAP_BROKEN: begin
                length    = FRAME_SYMBOLS + $urandom_range(2, 0);
                slot      = $urandom_range(FRAME_BITS + 1, 0);
                broken_at = slot < 2 ? slot : 2 * (slot - 1);
            end
            CAP_SHORT: length = $urandom_range(FRAME_SYMBOLS - 1, 1);
            default:   length = $urandom_range(FRAME_SYMBOLS + 14, 1);
        endcase
        for (int unsigned i = 0; i < length; i++) begin
            nominal = i == 0 ? HDR_MARK_US : i == 1 ? HDR_SPACE_US : BIT_MARK_US;
            if (kind == CAP_NOISE || i >= FRAME_SYMBOLS)
                pulse = DUR_W'($urandom_range(16'hFFFF, 0));
            else if (i == broken_at)
                pulse = pulse_out_of_window(nominal);
            else if (i > 1 && i % 2 == 1)
                pulse = bit_space($urandom_range(1, 0));
            else
                pulse = pulse_in_window(nominal);
            send_pulse(pulse, i == length - 1);
        end
    endtask

    initial begin
        int unsigned roll;
        i_rst_n                 <= 1'b0;
        pulse_if.valid          <= 1'b0;
        pulse_if.duration_us    <= '0;
        pulse_if.end_of_capture <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_pulse('0, 1'b1);
        send_pulse('1, 1'b1);

        send_pulse(DUR_W'(HDR_MARK_US * 7 / 10), 1'b0);
        send_pulse(DUR_W'(HDR_SPACE_US * 13 / 10), 1'b0);
        send_pulse(DUR_W'(BIT_MARK_US * 7 / 10), 1'b0);
        send_pulse(DUR_W'(SPACE_SPLIT_US + 1), 1'b0);
        send_pulse(DUR_W'(BIT_MARK_US * 13 / 10), 1'b0);
        send_pulse(DUR_W'(SPACE_SPLIT_US), 1'b1);

        send_pulse(DUR_W'(HDR_MARK_US * 13 / 10 + 1), 1'b0);
        send_pulse(DUR_W'(HDR_SPACE_US * 7 / 10 - 1), 1'b0);
        send_pulse(DUR_W'(BIT_MARK_US * 7 / 10 - 1), 1'b1);

        send_pulse(DUR_W'(HDR_MARK_US * 7 / 10 - 1), 1'b0);
        send_pulse(DUR_W'(HDR_SPACE_US * 13 / 10 + 1), 1'b0);
        send_pulse(DUR_W'(BIT_MARK_US * 13 / 10 + 1), 1'b0);
        send_pulse('0, 1'b1);

        while (pulses_sent < PULSE_BUDGET) begin
            roll = $urandom_range(99, 0);
            if (roll < 60)
                send_capture(CAP_CLEAN);
            else if (roll < 75)
                send_capture(CAP_BROKEN);
            else if (roll < 88)
                send_capture(CAP_SHORT);
            else
                send_capture(CAP_NOISE);
        end
        pulse_if.valid <= 1'b0;

        @(posedge i_clk);
        wait (results_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        int unsigned held;
        result_if.ready <= 1'b0;
        held = 0;
        while (held < RX_HOLD_CYCLES) begin
            @(posedge i_clk);
            held++;
        end
        forever begin
            @(posedge i_clk);
            result_if.ready <= steady_stretch() || $urandom_range(99, 0) >= IDLE_PERCENT;
        end
    end

endmodule

[sim.f]
rtl/core/necir_pkg.sv
rtl/core/necir_if.sv
rtl/core/necir_symbol_check.sv
rtl/core/nec_ir_pulse_decoder.sv
rtl/core/necir_checker.sv
bench/nec_ir_checker.sv
bench/tb.sv
